>>> hw/rtl/smj_pkg.sv
// Shared types, constants and codes for the sort-merge join block.
`timescale 1ns / 1ps
`default_nettype none
package smj_pkg;

  localparam int KEY_W = 32;
  localparam int ROW_W = 16;
  localparam int GROUP_DEPTH = 16;
  // Buffer never holds more than 16 rows, so one left row yields at most 16 pairs.
  localparam int CAP = (GROUP_DEPTH < 16) ? GROUP_DEPTH : 16;
  localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int FUNC_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_LEFT    = 3'd0,
    FN_RIGHT   = 3'd1,
    FN_LEND    = 3'd2,
    FN_REND    = 3'd3,
    FN_RESTART = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    PH_SEEK    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_MATCH   = 2'd2
  } phase_e;

  // One unit of work for the back end: n pairs of lrow against the buffer,
  // or a single status beat when n is zero.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [ROW_W-1:0] lrow;
    logic             want;
    logic             done;
    logic             ovf;
  } cmd_t;

  // Group buffer write port.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] data;
  } wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/smj_front.sv
// Front end: takes input items, runs the merge state and issues work commands.
`timescale 1ns / 1ps
`default_nettype none
module smj_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [smj_pkg::FUNC_W-1:0] func_i,
  input  wire logic [smj_pkg::KEY_W-1:0]  key_i,
  input  wire logic [smj_pkg::ROW_W-1:0]  row_i,
  output smj_pkg::cmd_t                  cmd_o,
  output smj_pkg::wr_t                   wr_o
);
  import smj_pkg::*;

  phase_e           phase_q, phase_d;
  logic [KEY_W-1:0] lkey_q, lkey_d, rkey_q, rkey_d, gkey_q, gkey_d;
  logic [ROW_W-1:0] lrow_q, lrow_d, rrow_q, rrow_d;
  logic             lp_q, lp_d, rp_q, rp_d, le_q, le_d, re_q, re_d, ovf_q, ovf_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             want_cur, done_cur, do_settle, emit;
  logic [ROW_W-1:0] emit_row;
  wr_t              wr;

  function automatic logic requested(phase_e ph, logic lp, logic le, logic rp, logic re);
    logic r;
    if (ph == PH_COLLECT) r = 1'b1;
    else if (ph == PH_MATCH) r = 1'b0;
    else if (!lp && !le) r = 1'b0;
    else if (!rp && !re) r = 1'b1;
    else r = 1'b0;
    return r;
  endfunction

  function automatic logic is_done(phase_e ph, logic lp, logic le, logic rp, logic re);
    return (ph == PH_SEEK) && ((le && !lp) || (re && !rp));
  endfunction

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    lkey_d    = lkey_q;
    lrow_d    = lrow_q;
    rkey_d    = rkey_q;
    rrow_d    = rrow_q;
    gkey_d    = gkey_q;
    lp_d      = lp_q;
    rp_d      = rp_q;
    le_d      = le_q;
    re_d      = re_q;
    ovf_d     = ovf_q;
    cnt_d     = cnt_q;
    do_settle = 1'b0;
    emit      = 1'b0;
    emit_row  = lrow_q;
    wr        = '0;
    want_cur  = requested(phase_q, lp_q, le_q, rp_q, re_q);
    done_cur  = is_done(phase_q, lp_q, le_q, rp_q, re_q);
    if (accept_i) begin
      case (func_i)
        FN_RESTART: begin
          phase_d = PH_SEEK;
          lkey_d  = '0;
          lrow_d  = '0;
          rkey_d  = '0;
          rrow_d  = '0;
          gkey_d  = '0;
          lp_d    = 1'b0;
          rp_d    = 1'b0;
          le_d    = 1'b0;
          re_d    = 1'b0;
          ovf_d   = 1'b0;
          cnt_d   = '0;
        end
        FN_LEND: begin
          le_d = 1'b1;
          if (phase_q == PH_MATCH) phase_d = PH_SEEK;
        end
        FN_REND: begin
          re_d = 1'b1;
          if (phase_q == PH_COLLECT) begin
            emit    = 1'b1;
            lp_d    = 1'b0;
            phase_d = PH_MATCH;
          end
        end
        FN_LEFT: begin
          if (!want_cur && !le_q && !done_cur) begin
            if (phase_q == PH_MATCH && key_i == gkey_q) begin
              emit     = 1'b1;
              emit_row = row_i;
            end else begin
              lkey_d    = key_i;
              lrow_d    = row_i;
              lp_d      = 1'b1;
              phase_d   = PH_SEEK;
              do_settle = 1'b1;
            end
          end
        end
        FN_RIGHT: begin
          if (want_cur && !re_q && !done_cur) begin
            if (phase_q == PH_COLLECT) begin
              if (key_i == gkey_q) begin
                if (cnt_q < CNT_W'(CAP)) begin
                  wr.en   = 1'b1;
                  wr.idx  = cnt_q[IDX_W-1:0];
                  wr.data = row_i;
                  cnt_d   = cnt_q + 1'b1;
                end else begin
                  ovf_d = 1'b1;
                end
              end else begin
                rkey_d  = key_i;
                rrow_d  = row_i;
                rp_d    = 1'b1;
                emit    = 1'b1;
                lp_d    = 1'b0;
                phase_d = PH_MATCH;
              end
            end else begin
              rkey_d    = key_i;
              rrow_d    = row_i;
              rp_d      = 1'b1;
              do_settle = 1'b1;
            end
          end
        end
        default: ;
      endcase
      // Drop the smaller side, or open a group on equal keys.
      if (do_settle && lp_d && rp_d) begin
        if (lkey_d < rkey_d) begin
          lp_d = 1'b0;
        end else if (rkey_d < lkey_d) begin
          rp_d = 1'b0;
        end else begin
          gkey_d  = rkey_d;
          wr.en   = 1'b1;
          wr.idx  = '0;
          wr.data = rrow_d;
          cnt_d   = CNT_W'(1);
          ovf_d   = 1'b0;
          rp_d    = 1'b0;
          phase_d = PH_COLLECT;
        end
      end
    end
  end

  // Command and buffer write.
  always_comb begin
    cmd_o.n    = emit ? cnt_q : '0;
    cmd_o.lrow = emit_row;
    cmd_o.done = is_done(phase_d, lp_d, le_d, rp_d, re_d);
    cmd_o.want = cmd_o.done ? 1'b0 : requested(phase_d, lp_d, le_d, rp_d, re_d);
    cmd_o.ovf  = ovf_d;
    wr_o       = wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
      lkey_q  <= '0;
      lrow_q  <= '0;
      rkey_q  <= '0;
      rrow_q  <= '0;
      gkey_q  <= '0;
      lp_q    <= 1'b0;
      rp_q    <= 1'b0;
      le_q    <= 1'b0;
      re_q    <= 1'b0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      lkey_q  <= lkey_d;
      lrow_q  <= lrow_d;
      rkey_q  <= rkey_d;
      rrow_q  <= rrow_d;
      gkey_q  <= gkey_d;
      lp_q    <= lp_d;
      rp_q    <= rp_d;
      le_q    <= le_d;
      re_q    <= re_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/smj_fifo.sv
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module smj_fifo (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire smj_pkg::cmd_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output smj_pkg::cmd_t data_o,
  output logic       empty_o
);
  import smj_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/smj_back.sv
// Back end: group buffer, pair replay and the output register.
`timescale 1ns / 1ps
`default_nettype none
module smj_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire smj_pkg::wr_t              wr_i,
  input  wire smj_pkg::cmd_t             cmd_i,
  input  wire logic                      cmd_empty_i,
  output logic                           cmd_pop_o,
  input  wire logic                      pop_i,
  output logic                           empty_o,
  output logic                           pair_valid_o,
  output logic [smj_pkg::ROW_W-1:0]      left_row_o,
  output logic [smj_pkg::ROW_W-1:0]      right_row_o,
  output logic                           want_right_o,
  output logic                           done_res_o,
  output logic                           overflow_o,
  output logic                           last_o
);
  import smj_pkg::*;

  logic [ROW_W-1:0] mem_q [CAP];

  cmd_t             cmd_q, cmd_d, src;
  logic [CNT_W-1:0] idx_q, idx_d, src_idx, nxt_idx;
  logic             busy_q, busy_d, ov_q, ov_d;
  logic             can_load, cont, take_new, load, is_pair, is_last;

  assign can_load  = !ov_q || pop_i;
  assign cont      = can_load && busy_q;
  assign take_new  = can_load && !busy_q && !cmd_empty_i;
  assign load      = cont || take_new;
  assign cmd_pop_o = take_new;

  always_comb begin
    src     = cont ? cmd_q : cmd_i;
    src_idx = cont ? idx_q : '0;
    nxt_idx = src_idx + 1'b1;
    is_pair = (src.n != '0);
    is_last = !is_pair || (nxt_idx == src.n);
    busy_d  = busy_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    ov_d    = ov_q;
    if (can_load) ov_d = load;
    if (load) begin
      busy_d = is_pair && !is_last;
      cmd_d  = src;
      idx_d  = nxt_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.idx] <= wr_i.data;
  end

  // Output payload; the buffer read is registered here.
  always_ff @(posedge clk_i) begin
    if (load) begin
      pair_valid_o <= is_pair;
      left_row_o   <= is_pair ? src.lrow : '0;
      right_row_o  <= is_pair ? mem_q[src_idx[IDX_W-1:0]] : '0;
      want_right_o <= src.want;
      done_res_o   <= src.done;
      overflow_o   <= src.ovf;
      last_o       <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
      idx_q  <= '0;
      cmd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      ov_q   <= ov_d;
      idx_q  <= idx_d;
      cmd_q  <= cmd_d;
    end
  end

  assign empty_o = !ov_q;

endmodule
`default_nettype wire

>>> hw/rtl/sort_merge_join.sv
// Top level of the sort-merge join: front end, command queue, back end.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel  | handshake               | beat
//  ---------+-------------------------+---------------------------------------------
//  input    | push_i / full_o         | func_i, key_i, row_i
//  result   | pop_i / empty_o         | pair_valid_o, left_row_o, right_row_o,
//           |                         | want_right_o, done_res_o, overflow_o, last_o
//
//  A beat that yields no pair is taken every cycle while full_o is low; its status
//  beat passes through the queue and then the output register to the result ports.
//  A beat that yields n pairs (n up to 16) keeps full_o high until its last
//  pair beat is popped; the single buffer read port replays one pair per cycle
//  while the output is not stalled.
//  Reset is asynchronous, active low; the group buffer needs no clearing.
//  Output stalls back up through the two-entry command queue into full_o.
//
module sort_merge_join (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push_i,
  output logic                           full_o,
  input  wire logic [smj_pkg::FUNC_W-1:0] func_i,
  input  wire logic [smj_pkg::KEY_W-1:0]  key_i,
  input  wire logic [smj_pkg::ROW_W-1:0]  row_i,
  input  wire logic                      pop_i,
  output logic                           empty_o,
  output logic                           pair_valid_o,
  output logic [smj_pkg::ROW_W-1:0]      left_row_o,
  output logic [smj_pkg::ROW_W-1:0]      right_row_o,
  output logic                           want_right_o,
  output logic                           done_res_o,
  output logic                           overflow_o,
  output logic                           last_o
);
  import smj_pkg::*;

  cmd_t cmd_in, cmd_out;
  wr_t  wr;
  logic q_full, q_empty, q_pop, accept, pend_q;

  // Hold new beats while a pair command is in flight: the buffer it replays
  // must not change under it.
  assign full_o = q_full || pend_q;
  assign accept = push_i && !full_o;

  smj_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .func_i   (func_i),
    .key_i    (key_i),
    .row_i    (row_i),
    .cmd_o    (cmd_in),
    .wr_o     (wr)
  );

  smj_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (cmd_out),
    .empty_o (q_empty)
  );

  smj_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .cmd_i        (cmd_out),
    .cmd_empty_i  (q_empty),
    .cmd_pop_o    (q_pop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .pair_valid_o (pair_valid_o),
    .left_row_o   (left_row_o),
    .right_row_o  (right_row_o),
    .want_right_o (want_right_o),
    .done_res_o   (done_res_o),
    .overflow_o   (overflow_o),
    .last_o       (last_o)
  );

  // Set on a pair command, clear when its last pair beat leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (accept && (cmd_in.n != '0)) begin
      pend_q <= 1'b1;
    end else if (pop_i && !empty_o && pair_valid_o && last_o) begin
      pend_q <= 1'b0;
    end
  end

  a_pend_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> full_o)
    else $error("input accepted while pairs in flight");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pair_valid_o) |-> last_o)
    else $error("status beat not marked last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pair_valid_o) |-> (left_row_o == '0 && right_row_o == '0))
    else $error("status beat carries row ids");

  a_done_no_want: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && done_res_o) |-> !want_right_o)
    else $error("done beat requests right side");

  a_pair_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pair_valid_o) |-> pend_q)
    else $error("pair beat without pending command");

endmodule
`default_nettype wire

>>> tb/smj_scoreboard.sv
// Scoreboard for the sort-merge join: mirrors the join and checks every result beat.
`timescale 1ns / 1ps
module smj_scoreboard (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic                       full_i,
  input  logic [smj_pkg::FUNC_W-1:0] func_i,
  input  logic [smj_pkg::KEY_W-1:0]  key_i,
  input  logic [smj_pkg::ROW_W-1:0]  row_i,
  input  logic                       pop_i,
  input  logic                       empty_i,
  input  logic                       pair_valid_i,
  input  logic [smj_pkg::ROW_W-1:0]  left_row_i,
  input  logic [smj_pkg::ROW_W-1:0]  right_row_i,
  input  logic                       want_right_i,
  input  logic                       done_res_i,
  input  logic                       overflow_i,
  input  logic                       last_i,
  output int                         errors_o,
  output int                         pending_o,
  output int                         beats_in_o,
  output int                         beats_out_o,
  output int                         pairs_o,
  output logic                       next_right_o,
  output logic                       join_done_o
);
  import smj_pkg::*;

  typedef struct packed {
    logic             pv;
    logic [ROW_W-1:0] lrow;
    logic [ROW_W-1:0] rrow;
    logic             want;
    logic             done;
    logic             ovf;
    logic             last;
  } beat_t;

  beat_t expected_q[$];

  // Mirror of the join state.
  logic [KEY_W-1:0] l_key, r_key, g_key;
  logic [ROW_W-1:0] l_row, r_row;
  logic             l_have, r_have, l_end, r_end, g_ovf;
  logic [ROW_W-1:0] g_rows [CAP];
  int               g_cnt;
  phase_e           ph;

  function automatic void clear_join();
    l_key = '0;
    r_key = '0;
    g_key = '0;
    l_row = '0;
    r_row = '0;
    l_have = 1'b0;
    r_have = 1'b0;
    l_end = 1'b0;
    r_end = 1'b0;
    g_ovf = 1'b0;
    g_cnt = 0;
    ph = PH_SEEK;
  endfunction

  function automatic logic side_wanted();
    if (ph == PH_COLLECT) return 1'b1;
    if (ph == PH_MATCH) return 1'b0;
    if (!l_have && !l_end) return 1'b0;
    if (!r_have && !r_end) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic joined_out();
    return (ph == PH_SEEK) && ((l_end && !l_have) || (r_end && !r_have));
  endfunction

  // Drop the side with the smaller key, or open a group on equal keys.
  function automatic void settle();
    if (ph != PH_SEEK || !l_have || !r_have) return;
    if (l_key < r_key) begin
      l_have = 1'b0;
    end else if (r_key < l_key) begin
      r_have = 1'b0;
    end else begin
      g_key = r_key;
      g_rows[0] = r_row;
      g_cnt = 1;
      g_ovf = 1'b0;
      r_have = 1'b0;
      ph = PH_COLLECT;
    end
  endfunction

  // Advance the mirror by one input beat and queue the result beats it causes.
  task automatic join_step(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                           input logic [ROW_W-1:0] r);
    logic             want;
    logic             fin;
    logic [ROW_W-1:0] lr;
    int               n;
    int               i;
    beat_t            b;
    want = side_wanted();
    n = 0;
    lr = '0;
    case (f)
      FN_RESTART: clear_join();
      FN_LEND: begin
        l_end = 1'b1;
        if (ph == PH_MATCH) ph = PH_SEEK;
      end
      FN_REND: begin
        r_end = 1'b1;
        if (ph == PH_COLLECT) begin
          n = g_cnt;
          lr = l_row;
          l_have = 1'b0;
          ph = PH_MATCH;
        end
      end
      FN_LEFT: begin
        if (!want && !l_end && !joined_out()) begin
          if (ph == PH_MATCH && k == g_key) begin
            n = g_cnt;
            lr = r;
          end else begin
            l_key = k;
            l_row = r;
            l_have = 1'b1;
            ph = PH_SEEK;
            settle();
          end
        end
      end
      FN_RIGHT: begin
        if (want && !r_end && !joined_out()) begin
          if (ph == PH_COLLECT) begin
            if (k == g_key) begin
              if (g_cnt < CAP) begin
                g_rows[g_cnt] = r;
                g_cnt++;
              end else begin
                g_ovf = 1'b1;
              end
            end else begin
              r_key = k;
              r_row = r;
              r_have = 1'b1;
              n = g_cnt;
              lr = l_row;
              l_have = 1'b0;
              ph = PH_MATCH;
            end
          end else begin
            r_key = k;
            r_row = r;
            r_have = 1'b1;
            settle();
          end
        end
      end
      default: ;
    endcase
    fin = joined_out();
    b.want = fin ? 1'b0 : side_wanted();
    b.done = fin;
    b.ovf = g_ovf;
    if (n == 0) begin
      b.pv = 1'b0;
      b.lrow = '0;
      b.rrow = '0;
      b.last = 1'b1;
      expected_q.push_back(b);
    end else begin
      for (i = 0; i < n; i++) begin
        b.pv = 1'b1;
        b.lrow = lr;
        b.rrow = g_rows[i];
        b.last = (i == n - 1);
        expected_q.push_back(b);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [ROW_W-1:0] exp_v,
                             input logic [ROW_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Sample mid-cycle: every signal here changes only at the rising edge,
  // so this sees exactly what the next rising edge will take.
  always @(negedge clk_i) begin
    beat_t exp_b;
    if (!rst_ni) begin
      clear_join();
      expected_q.delete();
      errors_o = 0;
      beats_in_o = 0;
      beats_out_o = 0;
      pairs_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        beats_out_o++;
        if (pair_valid_i === 1'b1) pairs_o++;
        if (expected_q.size() == 0) begin
          errors_o++;
          $display("%0t: result beat with nothing expected, expected none, actual pv=%b l=%h r=%h",
                   $time, pair_valid_i, left_row_i, right_row_i);
        end else begin
          exp_b = expected_q.pop_front();
          check_field("pair_valid", exp_b.pv, pair_valid_i);
          check_field("left_row", exp_b.lrow, left_row_i);
          check_field("right_row", exp_b.rrow, right_row_i);
          check_field("want_right", exp_b.want, want_right_i);
          check_field("done_res", exp_b.done, done_res_i);
          check_field("overflow", exp_b.ovf, overflow_i);
          check_field("last", exp_b.last, last_i);
        end
      end
      if (push_i && !full_i) begin
        beats_in_o++;
        join_step(func_i, key_i, row_i);
      end
    end
    pending_o = expected_q.size();
    next_right_o = side_wanted();
    join_done_o = joined_out();
  end

endmodule

>>> tb/testbench.sv
// Top of the sort-merge join testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import smj_pkg::*;

  // Run limit for the watchdog; far above the slowest correct run, even with
  // every item replaying a full group into a receiver that stalls at the
  // highest idle rate used below.
  localparam int LIMIT = 500000;
  // A func code the block does not use; it must be ignored.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              push_i;
  logic [FUNC_W-1:0] func_i;
  logic [KEY_W-1:0]  key_i;
  logic [ROW_W-1:0]  row_i;
  logic              pop_i = 1'b0;

  wire               full_o;
  wire               empty_o;
  wire               pair_valid_o;
  wire [ROW_W-1:0]   left_row_o;
  wire [ROW_W-1:0]   right_row_o;
  wire               want_right_o;
  wire               done_res_o;
  wire               overflow_o;
  wire               last_o;

  int                errors;
  int                pending;
  int                beats_in;
  int                beats_out;
  int                pairs;
  logic              next_right;
  logic              join_done;

  int                snd_idle = 18;
  int                rcv_idle = 76;
  int                sent = 0;
  int                cycles = 0;

  always #2 clk_i = ~clk_i;

  sort_merge_join dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .func_i      (func_i),
    .key_i       (key_i),
    .row_i       (row_i),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .pair_valid_o(pair_valid_o),
    .left_row_o  (left_row_o),
    .right_row_o (right_row_o),
    .want_right_o(want_right_o),
    .done_res_o  (done_res_o),
    .overflow_o  (overflow_o),
    .last_o      (last_o)
  );

  // The scoreboard predicts each accepted beat at the falling edge before the
  // rising edge that takes it, so its demand outputs are settled whenever the
  // stimulus below looks at them right after an acceptance edge.
  smj_scoreboard chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_i      (full_o),
    .func_i      (func_i),
    .key_i       (key_i),
    .row_i       (row_i),
    .pop_i       (pop_i),
    .empty_i     (empty_o),
    .pair_valid_i(pair_valid_o),
    .left_row_i  (left_row_o),
    .right_row_i (right_row_o),
    .want_right_i(want_right_o),
    .done_res_i  (done_res_o),
    .overflow_i  (overflow_o),
    .last_i      (last_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .beats_in_o  (beats_in),
    .beats_out_o (beats_out),
    .pairs_o     (pairs),
    .next_right_o(next_right),
    .join_done_o (join_done)
  );

  // Receiver: stall at random, at the rate of the current phase.
  always @(posedge clk_i) begin
    pop_i <= ($urandom_range(99) >= rcv_idle);
  end

  // Watchdog: end the run if the drain never completes.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Timed out after %0d cycles with %0d result beats outstanding",
               cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one beat and hold it until the block takes it. Idle gaps go in
  // front of the beat; with no gap, push stays high from the previous beat
  // so back-to-back beats get exactly one assignment per edge.
  task automatic send(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                      input logic [ROW_W-1:0] r);
    while ($urandom_range(99) < snd_idle) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    func_i <= f;
    key_i  <= k;
    row_i  <= r;
    do @(posedge clk_i); while (full_o);
    sent++;
  endtask

  // Hold the input off until every expected result beat has been popped.
  task automatic drain();
    push_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  // One join: build two sorted streams over a shared key walk, then feed
  // whichever side the block asks for, ending a side once it runs dry.
  // Sprinkle noise beats (any func, any key) to break the sequence now and
  // then. Some joins carry a right group longer than the buffer.
  task automatic feed_join();
    logic [KEY_W-1:0] lk[$];
    logic [KEY_W-1:0] rk[$];
    logic [ROW_W-1:0] lr[$];
    logic [ROW_W-1:0] rr[$];
    logic [KEY_W-1:0] kv;
    int               steps, big, s, cl, cr, li, ri, guard;
    kv = $urandom;
    steps = $urandom_range(2, 6);
    big = ($urandom_range(7) == 0) ? $urandom_range(1, steps) : 0;
    for (s = 0; s < steps; s++) begin
      kv = kv + $urandom_range(1, 3);
      if (s == big - 1) begin
        cl = $urandom_range(1, 2);
        cr = $urandom_range(CAP + 1, CAP + 3);
      end else begin
        cl = $urandom_range(0, 3);
        cr = $urandom_range(0, 3);
      end
      repeat (cl) begin
        lk.push_back(kv);
        lr.push_back(ROW_W'($urandom));
      end
      repeat (cr) begin
        rk.push_back(kv);
        rr.push_back(ROW_W'($urandom));
      end
    end
    li = 0;
    ri = 0;
    guard = 0;
    while (!join_done && guard < 100) begin
      guard++;
      if ($urandom_range(99) < 5) begin
        send(FUNC_W'($urandom_range(7)), KEY_W'($urandom), ROW_W'($urandom));
      end else if (!next_right) begin
        if (li < lk.size()) begin
          send(FN_LEFT, lk[li], lr[li]);
          li++;
        end else begin
          send(FN_LEND, KEY_W'($urandom), ROW_W'($urandom));
        end
      end else begin
        if (ri < rk.size()) begin
          send(FN_RIGHT, rk[ri], rr[ri]);
          ri++;
        end else begin
          send(FN_REND, KEY_W'($urandom), ROW_W'($urandom));
        end
      end
    end
    // Occasionally poke a finished join before clearing it.
    if ($urandom_range(3) == 0) send(FN_LEFT, KEY_W'($urandom), ROW_W'($urandom));
    send(FN_RESTART, KEY_W'($urandom), ROW_W'($urandom));
  endtask

  initial begin
    int i;
    int round;
    int target;
    rst_ni <= 1'b0;
    push_i <= 1'b0;
    func_i <= FN_LEFT;
    key_i  <= '0;
    row_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a group of 17 right rows on key zero overflows the buffer.
    send(FN_LEFT, '0, '0);
    send(FN_RIGHT, '0, '1);
    for (i = 0; i < 16; i++) send(FN_RIGHT, '0, ROW_W'(16'h5A5A ^ i));
    // A left record while collecting is not requested: ignore it.
    send(FN_LEFT, 32'h1, 16'h1);
    // A larger right key closes the group: sixteen pairs, overflow set.
    send(FN_RIGHT, '1, 16'h0);
    // A second left row on the same key replays the whole group.
    send(FN_LEFT, '0, 16'hABCD);
    // Top key matches the held right record and opens a new group.
    send(FN_LEFT, '1, '1);
    // Right end mark while collecting closes it; left end mark ends the join.
    send(FN_REND, '0, '0);
    send(FN_LEND, '1, '1);
    // After the end: a record and an unused code are both ignored.
    send(FN_RIGHT, 32'h5, 16'h5);
    send(FN_UNUSED, '1, '1);
    send(FN_RESTART, '0, '0);

    // Random joins in three idle profiles, draining fully between them.
    for (round = 0; round < 3; round++) begin
      case (round)
        0: begin
          snd_idle = 18;
          rcv_idle = 76;
        end
        1: begin
          snd_idle = 76;
          rcv_idle = 18;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      target = sent + 90;
      while (sent < target) feed_join();
      drain();
    end

    // Let any stray beat surface before the verdict.
    drain();
    repeat (40) @(posedge clk_i);

    $display("Covered %0d input beats over directed and random joins (overflow, ends, noise)",
             beats_in);
    $display("Checked %0d result beats, %0d of them joined pairs, with %0d mismatches",
             beats_out, pairs, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
